>>> rtl/core/gqlay_pkg.sv
// Shared types, constants and helpers of the glyph quad layout block.
package gqlay_pkg;

  localparam int GLYPH_CODES = 256;
  localparam int KERN_PAIRS  = 65536;
  localparam int MAX_TEXT    = 4096;

  localparam int GLYPH_AW = $clog2(GLYPH_CODES);
  localparam int KERN_AW  = $clog2(KERN_PAIRS);
  localparam int TIDX_W   = 13;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int NUM_REGS = 8;
  localparam int CFG_AW   = $clog2(NUM_REGS * 4);
  localparam int CFG_DW   = 32;

  // request type codes on the input channel
  localparam logic [2:0] REQ_GLYPH = 3'd0;
  localparam logic [2:0] REQ_KERN  = 3'd1;
  localparam logic [2:0] REQ_START = 3'd2;
  localparam logic [2:0] REQ_CHAR  = 3'd3;
  localparam logic [2:0] REQ_END   = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_QUAD   = 2'd0;
  localparam logic [1:0] KIND_CURSOR = 2'd1;
  localparam logic [1:0] KIND_SEL    = 2'd2;

  localparam logic signed [15:0] CURSOR_W = 16'sd32;

  typedef enum logic [2:0] {
    OP_GLYPH,
    OP_KERN,
    OP_START,
    OP_CHAR,
    OP_END
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [7:0]       code;
    logic [7:0]       prev;
    logic [10:0]      ax;
    logic [10:0]      ay;
    logic [7:0]       w;
    logic [7:0]       h;
    logic signed [7:0] ox;
    logic signed [7:0] oy;
    logic [7:0]       adv;
    logic signed [7:0] kamt;
  } item_t;

  typedef struct packed {
    logic [10:0]       ax;
    logic [10:0]       ay;
    logic [7:0]        w;
    logic [7:0]        h;
    logic signed [7:0] ox;
    logic signed [7:0] oy;
    logic [7:0]        adv;
  } glyph_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [TIDX_W-1:0]  char_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] size_w;
    logic [15:0]        size_h;
    logic [10:0]        tex_x;
    logic [10:0]        tex_y;
    logic [7:0]         tex_w;
    logic [7:0]         tex_h;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [15:0]        scale;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [15:0]        font_px;
    logic               cap_en;
    logic [TIDX_W-1:0]  cursor;
    logic [TIDX_W-1:0]  sel_begin;
    logic [TIDX_W-1:0]  sel_end;
  } cfg_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) r = 16'sh7fff;
    else if (v < -20'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

>>> rtl/core/gqlay_in_if.sv
// Input item channel of the glyph quad layout block.
interface gqlay_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        req_type;
  logic [7:0]        char_code;
  logic [7:0]        prev_code;
  logic [10:0]       atlas_x;
  logic [10:0]       atlas_y;
  logic [7:0]        glyph_w;
  logic [7:0]        glyph_h;
  logic signed [7:0] offset_x;
  logic signed [7:0] offset_y;
  logic [7:0]        advance;
  logic signed [7:0] kern_amount;

  modport source (output valid, req_type, char_code, prev_code, atlas_x, atlas_y,
                  glyph_w, glyph_h, offset_x, offset_y, advance, kern_amount,
                  input ready);
  modport sink   (input valid, req_type, char_code, prev_code, atlas_x, atlas_y,
                  glyph_w, glyph_h, offset_x, offset_y, advance, kern_amount,
                  output ready);
endinterface

>>> rtl/core/gqlay_out_if.sv
// Result item channel of the glyph quad layout block.
interface gqlay_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [12:0]        char_index;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] size_w;
  logic [15:0]        size_h;
  logic [10:0]        tex_x;
  logic [10:0]        tex_y;
  logic [7:0]         tex_w;
  logic [7:0]         tex_h;
  logic               last;

  modport source (output valid, kind, char_index, pos_x, pos_y, size_w, size_h,
                  tex_x, tex_y, tex_w, tex_h, last, input ready);
  modport sink   (input valid, kind, char_index, pos_x, pos_y, size_w, size_h,
                  tex_x, tex_y, tex_w, tex_h, last, output ready);
endinterface

>>> rtl/core/gqlay_cfg.sv
// APB configuration registers of the glyph quad layout block.
module gqlay_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gqlay_pkg::CFG_AW-1:0]  paddr,
  input  logic [gqlay_pkg::CFG_DW-1:0]  pwdata,
  output logic [gqlay_pkg::CFG_DW-1:0]  prdata,
  output logic                          pready,
  output gqlay_pkg::cfg_t               cfg_o
);
  import gqlay_pkg::*;

  typedef enum logic [2:0] {
    R_SCALE, R_ORIGIN_X, R_ORIGIN_Y, R_FONT_PX,
    R_CAP_EN, R_CURSOR, R_SEL_BEGIN, R_SEL_END
  } reg_e;

  cfg_t cfg_q;
  reg_e sel;
  logic wr;

  assign sel   = reg_e'(paddr[CFG_AW-1:2]);
  assign wr    = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale     <= 16'd4096;
      cfg_q.origin_x  <= '0;
      cfg_q.origin_y  <= '0;
      cfg_q.font_px   <= 16'd256;
      cfg_q.cap_en    <= 1'b0;
      cfg_q.cursor    <= '0;
      cfg_q.sel_begin <= '0;
      cfg_q.sel_end   <= '0;
    end else if (wr) begin
      case (sel)
        R_SCALE:     cfg_q.scale     <= pwdata[15:0];
        R_ORIGIN_X:  cfg_q.origin_x  <= pwdata[15:0];
        R_ORIGIN_Y:  cfg_q.origin_y  <= pwdata[15:0];
        R_FONT_PX:   cfg_q.font_px   <= pwdata[15:0];
        R_CAP_EN:    cfg_q.cap_en    <= pwdata[0];
        R_CURSOR:    cfg_q.cursor    <= pwdata[TIDX_W-1:0];
        R_SEL_BEGIN: cfg_q.sel_begin <= pwdata[TIDX_W-1:0];
        R_SEL_END:   cfg_q.sel_end   <= pwdata[TIDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (sel)
      R_SCALE:     prdata[15:0] = cfg_q.scale;
      R_ORIGIN_X:  prdata[15:0] = cfg_q.origin_x;
      R_ORIGIN_Y:  prdata[15:0] = cfg_q.origin_y;
      R_FONT_PX:   prdata[15:0] = cfg_q.font_px;
      R_CAP_EN:    prdata[0]    = cfg_q.cap_en;
      R_CURSOR:    prdata[TIDX_W-1:0] = cfg_q.cursor;
      R_SEL_BEGIN: prdata[TIDX_W-1:0] = cfg_q.sel_begin;
      R_SEL_END:   prdata[TIDX_W-1:0] = cfg_q.sel_end;
      default: ;
    endcase
  end
endmodule

>>> rtl/core/gqlay_front.sv
// Front end: accepts input items, decodes the request type, drops unknown ones.
module gqlay_front (
  gqlay_in_if.sink              in_ch,
  input  gqlay_pkg::back_stat_t stat_i,
  input  logic                  full_i,
  output logic                  push_o,
  output gqlay_pkg::item_t      item_o
);
  import gqlay_pkg::*;

  logic known;

  assign in_ch.ready = !full_i && !stat_i.clearing;

  always_comb begin
    known = 1'b1;
    item_o.op = OP_GLYPH;
    case (in_ch.req_type)
      REQ_GLYPH: item_o.op = OP_GLYPH;
      REQ_KERN:  item_o.op = OP_KERN;
      REQ_START: item_o.op = OP_START;
      REQ_CHAR:  item_o.op = OP_CHAR;
      REQ_END:   item_o.op = OP_END;
      default:   known = 1'b0;
    endcase
    item_o.code = in_ch.char_code;
    item_o.prev = in_ch.prev_code;
    item_o.ax   = in_ch.atlas_x;
    item_o.ay   = in_ch.atlas_y;
    item_o.w    = in_ch.glyph_w;
    item_o.h    = in_ch.glyph_h;
    item_o.ox   = in_ch.offset_x;
    item_o.oy   = in_ch.offset_y;
    item_o.adv  = in_ch.advance;
    item_o.kamt = in_ch.kern_amount;
  end

  assign push_o = in_ch.valid && in_ch.ready && known;
endmodule

>>> rtl/core/gqlay_queue.sv
// Short item queue between the front end and the layout engine.
module gqlay_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  gqlay_pkg::item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output gqlay_pkg::item_t head_o
);
  import gqlay_pkg::*;

  item_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_q, rp_q;
  logic [QUEUE_AW:0]   cnt_q;

  assign full_o  = cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QUEUE_AW+1)'(push_i) - (QUEUE_AW+1)'(pop_i);
    end
  end
endmodule

>>> rtl/core/gqlay_back.sv
// Layout engine: glyph and kerning tables, pen state, result sequencing.
module gqlay_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gqlay_pkg::cfg_t        cfg_i,
  input  logic                   q_valid_i,
  input  gqlay_pkg::item_t       q_item_i,
  output logic                   q_pop_o,
  output gqlay_pkg::back_stat_t  stat_o,
  gqlay_out_if.source            out_ch
);
  import gqlay_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RD, S_CALC, S_EMIT} state_e;

  state_e state_q;
  item_t  it_q;

  glyph_t                gmem [GLYPH_CODES];
  glyph_t                g_rd_q;
  logic                  g_vld_rd_q;
  logic [GLYPH_CODES-1:0] gvld_q;
  logic                  g_we;

  logic [8:0]            kmem [KERN_PAIRS];
  logic [8:0]            k_rd_q;
  logic [KERN_AW-1:0]    k_raddr, k_waddr, k_key_q;
  logic [8:0]            k_wdata;
  logic                  k_we;
  logic                  clr_busy_q;
  logic [KERN_AW-1:0]    clr_addr_q;

  logic signed [15:0]    pen_q;
  logic [7:0]            prev_q;
  logic [TIDX_W-1:0]     idx_q;
  logic signed [15:0]    sel_left_q;

  logic signed [24:0]    p_ox_q, p_oy_q;
  logic [23:0]           p_w_q, p_h_q;
  logic signed [26:0]    p_adv_q;

  res_t                  rec_q [3];
  logic [2:0]            pend_q;
  logic                  ov_q;
  res_t                  out_q;

  logic                  pop;
  logic [15:0]           key_char, key_load;
  logic signed [16:0]    scale_s;
  logic signed [9:0]     adv_kern;
  logic signed [7:0]     kern;

  assign stat_o.clearing = clr_busy_q;
  assign pop      = state_q == S_IDLE && q_valid_i && !clr_busy_q;
  assign q_pop_o  = pop;
  assign key_char = {q_item_i.code, prev_q};
  assign key_load = {q_item_i.code, q_item_i.prev};
  assign scale_s  = $signed({1'b0, cfg_i.scale});
  assign g_we     = pop && q_item_i.op == OP_GLYPH;

  always_comb begin
    k_raddr = (q_item_i.op == OP_KERN) ? key_load[KERN_AW-1:0] : key_char[KERN_AW-1:0];
    k_we    = 1'b0;
    k_waddr = k_key_q;
    k_wdata = {1'b1, it_q.kamt};
    if (clr_busy_q) begin
      k_we    = 1'b1;
      k_waddr = clr_addr_q;
      k_wdata = '0;
    end else if (state_q == S_RD && it_q.op == OP_KERN && !k_rd_q[8]) begin
      k_we = 1'b1;
    end
  end

  // table memories; the glyph read is held for the whole item
  always_ff @(posedge clk_i) begin
    if (g_we) begin
      gmem[q_item_i.code[GLYPH_AW-1:0]] <= '{ax: q_item_i.ax, ay: q_item_i.ay,
        w: q_item_i.w, h: q_item_i.h, ox: q_item_i.ox, oy: q_item_i.oy,
        adv: q_item_i.adv};
    end
    if (pop) g_rd_q <= gmem[q_item_i.code[GLYPH_AW-1:0]];
    if (k_we) kmem[k_waddr] <= k_wdata;
    k_rd_q <= kmem[k_raddr];
  end

  always_comb begin
    kern     = k_rd_q[8] ? $signed(k_rd_q[7:0]) : 8'sd0;
    adv_kern = $signed({2'b00, g_rd_q.adv}) + 10'(kern);
  end

  // result arithmetic
  logic signed [19:0] qx, qy, adv_sum, cy, sw_diff;
  logic [15:0]        sw, sh, ch;
  logic [17:0]        f3;
  logic signed [16:0] sx, sy;
  logic signed [18:0] sa;
  logic               cap, cur_hit, sel_on, sel_set, sel_hit, is_char;
  res_t               quad, cur, selr;

  always_comb begin
    is_char = it_q.op == OP_CHAR;
    sx = 17'(p_ox_q >>> 8);
    sy = 17'(p_oy_q >>> 8);
    sa = 19'(p_adv_q >>> 8);
    qx = 20'(pen_q) + 20'(sx);
    qy = 20'(cfg_i.origin_y) + 20'(sy);
    adv_sum = 20'(pen_q) + 20'(sa);
    sw = (p_w_q[23:8] > 16'd32767) ? 16'd32767 : p_w_q[23:8];
    sh = p_h_q[23:8];
    cy = 20'(cfg_i.origin_y) + $signed({7'd0, cfg_i.font_px[15:3]});
    f3 = {2'b00, cfg_i.font_px} + {1'b0, cfg_i.font_px, 1'b0};
    ch = f3[17:2];
    sw_diff = 20'(pen_q) - 20'(sel_left_q);

    cap     = cfg_i.cap_en;
    cur_hit = cap && idx_q == cfg_i.cursor;
    sel_on  = cfg_i.sel_begin < cfg_i.sel_end;
    sel_set = cap && sel_on && idx_q == cfg_i.sel_begin;
    sel_hit = cap && sel_on && !sel_set && idx_q == cfg_i.sel_end;

    quad = '{kind: KIND_QUAD, char_index: idx_q, pos_x: sat16(qx), pos_y: sat16(qy),
             size_w: sw, size_h: sh, tex_x: g_rd_q.ax, tex_y: g_rd_q.ay,
             tex_w: g_rd_q.w, tex_h: g_rd_q.h, last: 1'b0};
    cur  = '{kind: KIND_CURSOR, char_index: idx_q, pos_x: pen_q, pos_y: sat16(cy),
             size_w: CURSOR_W, size_h: ch, tex_x: '0, tex_y: '0, tex_w: '0,
             tex_h: '0, last: 1'b0};
    selr = '{kind: KIND_SEL, char_index: idx_q, pos_x: sel_left_q,
             pos_y: cfg_i.origin_y, size_w: sat16(sw_diff), size_h: cfg_i.font_px,
             tex_x: '0, tex_y: '0, tex_w: '0, tex_h: '0, last: 1'b0};
  end

  // pick the earliest pending record
  logic       slot_free;
  logic [1:0] pick;
  logic [2:0] pend_rest;
  res_t       out_d;

  always_comb begin
    slot_free = !ov_q || out_ch.ready;
    pick = 2'd2;
    if (pend_q[0]) pick = 2'd0;
    else if (pend_q[1]) pick = 2'd1;
    pend_rest = pend_q & ~(3'b001 << pick);
    out_d = rec_q[pick];
    out_d.last = pend_rest == '0;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      p_ox_q  <= $signed(g_rd_q.ox) * scale_s;
      p_oy_q  <= $signed(g_rd_q.oy) * scale_s;
      p_w_q   <= g_rd_q.w * cfg_i.scale;
      p_h_q   <= g_rd_q.h * cfg_i.scale;
      p_adv_q <= adv_kern * scale_s;
    end
    if (pop) begin
      it_q    <= q_item_i;
      k_key_q <= key_load[KERN_AW-1:0];
    end
    if (state_q == S_CALC) begin
      rec_q[0] <= quad;
      rec_q[1] <= cur;
      rec_q[2] <= selr;
    end
    if (state_q == S_EMIT && slot_free) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      gvld_q     <= '0;
      g_vld_rd_q <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      pen_q      <= '0;
      prev_q     <= '0;
      idx_q      <= '0;
      sel_left_q <= '0;
      pend_q     <= '0;
      ov_q       <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == '1) clr_busy_q <= 1'b0;
      end
      g_vld_rd_q <= gvld_q[q_item_i.code[GLYPH_AW-1:0]];
      if (g_we) gvld_q[q_item_i.code[GLYPH_AW-1:0]] <= 1'b1;
      if (state_q == S_EMIT && slot_free) ov_q <= 1'b1;
      else if (out_ch.ready) ov_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (pop) begin
            case (q_item_i.op)
              OP_KERN: state_q <= S_RD;
              OP_START: begin
                pen_q      <= cfg_i.origin_x;
                prev_q     <= '0;
                idx_q      <= '0;
                sel_left_q <= '0;
              end
              OP_CHAR: begin
                if (idx_q < TIDX_W'(MAX_TEXT)) begin
                  prev_q  <= q_item_i.code;
                  state_q <= S_RD;
                end
              end
              OP_END:  state_q <= S_CALC;
              default: ;
            endcase
          end
        end
        S_RD: begin
          if (it_q.op == OP_CHAR && g_vld_rd_q) state_q <= S_CALC;
          else state_q <= S_IDLE;
          if (it_q.op == OP_CHAR && !g_vld_rd_q) idx_q <= idx_q + 1'b1;
        end
        S_CALC: begin
          pend_q <= {sel_hit, cur_hit, is_char};
          if (sel_set) sel_left_q <= pen_q;
          if (is_char) begin
            pen_q <= sat16(adv_sum);
            idx_q <= idx_q + 1'b1;
          end
          state_q <= (is_char || cur_hit || sel_hit) ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (slot_free) begin
            pend_q <= pend_rest;
            if (pend_rest == '0) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = ov_q;
  assign out_ch.kind       = out_q.kind;
  assign out_ch.char_index = out_q.char_index;
  assign out_ch.pos_x      = out_q.pos_x;
  assign out_ch.pos_y      = out_q.pos_y;
  assign out_ch.size_w     = out_q.size_w;
  assign out_ch.size_h     = out_q.size_h;
  assign out_ch.tex_x      = out_q.tex_x;
  assign out_ch.tex_y      = out_q.tex_y;
  assign out_ch.tex_w      = out_q.tex_w;
  assign out_ch.tex_h      = out_q.tex_h;
  assign out_ch.last       = out_q.last;
endmodule

>>> rtl/core/glyph_quad_layout.sv
// Top level of the glyph quad layout block.
//  channel  | dir | handshake          | carries
//  in_ch    | in  | valid/ready        | request: loads, start, character, end
//  out_ch   | out | valid/ready        | quad, cursor or selection rectangle
//  apb      | in  | psel/penable/pready| eight configuration registers
// A character passes through the engine sequencer, which reads the tables,
// multiplies and then emits one result per pending record: quad, cursor,
// selection. After reset the kerning table is cleared, entry by entry,
// while in_ch.ready stays low. The queue keeps taking items while the
// engine waits on out_ch, until the queue is full.
module glyph_quad_layout (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gqlay_in_if.sink                      in_ch,
  gqlay_out_if.source                   out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gqlay_pkg::CFG_AW-1:0]  paddr,
  input  logic [gqlay_pkg::CFG_DW-1:0]  pwdata,
  output logic [gqlay_pkg::CFG_DW-1:0]  prdata,
  output logic                          pready
);
  import gqlay_pkg::*;

  cfg_t       cfg;
  back_stat_t stat;
  item_t      push_item, head;
  logic       push, full, pop, q_valid;

  gqlay_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  gqlay_front u_front (
    .in_ch, .stat_i(stat), .full_i(full), .push_o(push), .item_o(push_item)
  );

  gqlay_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .item_i(push_item), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .head_o(head)
  );

  gqlay_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .q_valid_i(q_valid), .q_item_i(head),
    .q_pop_o(pop), .stat_o(stat), .out_ch
  );
endmodule

>>> rtl/core/gqlay_checker.sv
// Port-level checks of the glyph quad layout block and their bind.
module gqlay_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [15:0] out_size_w,
  input logic [10:0] out_tex_x,
  input logic [7:0]  out_tex_w,
  input logic        pready
);
  import gqlay_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_size_w))
    else $error("result changed while stalled");

  a_tex_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind != KIND_QUAD |-> out_tex_x == '0 && out_tex_w == '0)
    else $error("texture rectangle on a cursor or selection item");

  a_cursor_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind == KIND_CURSOR |-> out_size_w == CURSOR_W)
    else $error("cursor width wrong");

  a_pready: assert property (@(posedge clk_i) pready)
    else $error("pready low");
endmodule

bind glyph_quad_layout gqlay_checker u_gqlay_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_kind(out_ch.kind), .out_size_w(out_ch.size_w), .out_tex_x(out_ch.tex_x),
  .out_tex_w(out_ch.tex_w), .pready(pready)
);
